>>> rtl/core/call_traffic_erlang_histogram_macros.svh
// ---------------------------------------------------------------------------
// call_traffic_erlang_histogram_macros.svh
// Assertion macros shared by the histogram RTL.
// ---------------------------------------------------------------------------
`ifndef CALL_TRAFFIC_ERLANG_HISTOGRAM_MACROS_SVH
`define CALL_TRAFFIC_ERLANG_HISTOGRAM_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CTEH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define CTEH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/cteh_pkg.sv
// ---------------------------------------------------------------------------
// cteh_pkg
// Types and constants of the call traffic Erlang histogram.
// ---------------------------------------------------------------------------
package cteh_pkg;

	// bin store geometry
	localparam int MAX_BINS = 1024;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int BIU_W    = $clog2(MAX_BINS + 1);

	// field widths
	localparam int CMD_W   = 2;
	localparam int TIME_W  = 27;
	localparam int TOTAL_W = 48;
	localparam int ERL_W   = 40;
	localparam int FRAC_W  = 16;
	// bits of a total that go below the integer Erlang part (ERL_W = 24 + 16)
	localparam int LOW_W   = ERL_W - FRAC_W;
	// time of day plus one bin, wide enough for the bin walk
	localparam int LO_W    = TIME_W + BIN_W + 1;

	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [ERL_W-1:0]   erl_t;
	typedef logic [BIN_W-1:0]   bin_t;
	typedef logic [BIU_W-1:0]   biu_t;
	typedef logic [LO_W-1:0]    lo_t;

	// commands
	localparam cmd_t CMD_ADD   = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	// day and step
	localparam int DAY_MS_I     = 86400000;
	localparam int STEP_RESET_I = 900000;
	localparam time_t DAY_MS     = TIME_W'(DAY_MS_I);
	localparam time_t STEP_RESET = TIME_W'(STEP_RESET_I);
	// steps below this give more than MAX_BINS bins
	localparam time_t STEP_FULL  = TIME_W'((DAY_MS_I + MAX_BINS - 1) / MAX_BINS);
	localparam biu_t BIU_RESET   = BIU_W'((DAY_MS_I + STEP_RESET_I - 1) / STEP_RESET_I);
	localparam biu_t BIU_FULL    = BIU_W'(MAX_BINS);

	localparam total_t TOTAL_MAX = '1;
	localparam erl_t   ERL_MAX   = '1;

	// shared divider: dividend shift register and iteration counter
	localparam int DVD_W     = ERL_W;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

endpackage

>>> rtl/core/cteh_ifs.sv
// ---------------------------------------------------------------------------
// cteh_ifs
// Valid/ready channels of the histogram: request, result and step config.
// ---------------------------------------------------------------------------
interface cteh_req_if;
	logic               valid;
	logic               ready;
	cteh_pkg::cmd_t     command;
	cteh_pkg::time_t    call_start_ms;
	cteh_pkg::time_t    call_end_ms;
	cteh_pkg::bin_t     read_bin;

	modport source (output valid, command, call_start_ms, call_end_ms, read_bin,
		input ready);
	modport sink (input valid, command, call_start_ms, call_end_ms, read_bin,
		output ready);
endinterface

interface cteh_rsp_if;
	logic               valid;
	logic               ready;
	cteh_pkg::bin_t     bin_out;
	cteh_pkg::erl_t     erlangs_q16;
	logic               bin_valid;

	modport source (output valid, bin_out, erlangs_q16, bin_valid, input ready);
	modport sink (input valid, bin_out, erlangs_q16, bin_valid, output ready);
endinterface

interface cteh_cfg_if;
	logic               valid;
	logic               ready;
	cteh_pkg::time_t    step_ms;

	modport source (output valid, step_ms, input ready);
	modport sink (input valid, step_ms, output ready);
endinterface

>>> rtl/core/call_traffic_erlang_histogram.sv
// ---------------------------------------------------------------------------
// call_traffic_erlang_histogram
// Time-of-day call traffic histogram with Erlang readout, built around one
// shared restoring divider and a single-port bin memory.
// ---------------------------------------------------------------------------
//  channel  dir  words
//  req      in   add call / read bin / clear all
//  rsp      out  one word per read: bin, Erlangs Q24.16, bin valid
//  cfg      in   step_ms write, retunes bins in use
//
//  Add call: 27-bit divide for the start bin, then a read and a write per bin spanned.
//  Read: 40-step quotient of total*2^16 / step, skipped when the result saturates.
//  Clear and reset: sweep of all 1024 words of the bin memory, req not ready.
//  Step write: divide of the day by the step for bins in use, unless step is zero or tiny.
//  A finished read waits in an output register; new words are taken meanwhile.
`include "call_traffic_erlang_histogram_macros.svh"

module call_traffic_erlang_histogram (
	input  logic clk,
	input  logic arst_n,
	cteh_req_if.sink   req,
	cteh_rsp_if.source rsp,
	cteh_cfg_if.sink   cfg
);

	// sequencer states
	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CLR    = 4'd2;
	localparam logic [3:0] S_CFG    = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_POST   = 4'd5;
	localparam logic [3:0] S_ADD_RD = 4'd6;
	localparam logic [3:0] S_ADD_WR = 4'd7;
	localparam logic [3:0] S_RD_MEM = 4'd8;
	localparam logic [3:0] S_RD_CHK = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	// divider jobs
	localparam logic [1:0] OP_BIU   = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_ERL   = 2'd2;

	localparam int TPAD_W = cteh_pkg::DVD_W - cteh_pkg::TIME_W;
	localparam int DPAD_W = cteh_pkg::DVD_W - cteh_pkg::TIME_W - 1;

	logic [3:0]                         state_q;
	cteh_pkg::bin_t                     clr_cnt_q;
	cteh_pkg::time_t                    step_q;
	cteh_pkg::biu_t                     biu_q;
	logic                               rsp_valid_q;

	logic [1:0]                         op_q;
	cteh_pkg::time_t                    div_rem_q;
	logic [cteh_pkg::DVD_W-1:0]         div_dvd_q;
	logic [cteh_pkg::DVD_W-1:0]         div_quo_q;
	logic [cteh_pkg::DIV_CNT_W-1:0]     div_cnt_q;
	cteh_pkg::time_t                    start_q;
	cteh_pkg::time_t                    end_q;
	cteh_pkg::bin_t                     bin_q;
	cteh_pkg::lo_t                      lo_q;
	cteh_pkg::lo_t                      hi_q;
	cteh_pkg::bin_t                     rd_bin_q;
	cteh_pkg::erl_t                     res_erl_q;
	logic                               res_bv_q;

	cteh_pkg::bin_t                     rsp_bin_q;
	cteh_pkg::erl_t                     rsp_erl_q;
	logic                               rsp_bv_q;

	cteh_pkg::total_t                   bin_totals_q [cteh_pkg::MAX_BINS];
	cteh_pkg::total_t                   rd_data_q;

	logic                               req_acc;
	logic                               cfg_acc;
	logic                               out_free;
	logic                               sweep_last;
	logic                               div_last;
	logic [cteh_pkg::TIME_W:0]          div_trial;
	logic [cteh_pkg::TIME_W:0]          div_diff;
	logic                               div_ge;
	cteh_pkg::time_t                    div_rem_next;
	logic [cteh_pkg::TIME_W:0]          day_sum;
	logic                               read_ok;
	logic                               add_skip;
	logic                               start_past;
	cteh_pkg::lo_t                      start_w;
	cteh_pkg::lo_t                      end_w;
	cteh_pkg::lo_t                      os_w;
	cteh_pkg::lo_t                      oe_w;
	cteh_pkg::lo_t                      ovl_w;
	logic [cteh_pkg::TOTAL_W:0]         sum_w;
	cteh_pkg::biu_t                     bin_next;
	logic                               walk_done;
	logic                               erl_sat;
	logic                               mem_we;
	cteh_pkg::bin_t                     mem_addr;
	cteh_pkg::total_t                   mem_wd;

	// handshakes; a step write wins over a request in the same cycle
	assign cfg.ready = (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.bin_out     = rsp_bin_q;
	assign rsp.erlangs_q16 = rsp_erl_q;
	assign rsp.bin_valid   = rsp_bv_q;

	assign sweep_last = (clr_cnt_q == cteh_pkg::bin_t'(cteh_pkg::MAX_BINS - 1));

	// one restoring divide step per cycle
	always_comb begin
		div_trial    = {div_rem_q, div_dvd_q[cteh_pkg::DVD_W-1]};
		div_diff     = div_trial - {1'b0, step_q};
		div_ge       = (div_trial >= {1'b0, step_q});
		div_rem_next = div_ge ? div_diff[cteh_pkg::TIME_W-1:0]
			: div_trial[cteh_pkg::TIME_W-1:0];
		div_last     = (div_cnt_q == cteh_pkg::DIV_CNT_W'(1));
	end

	// request decode and post-divide checks
	always_comb begin
		day_sum    = {1'b0, cteh_pkg::DAY_MS} + {1'b0, step_q} - (cteh_pkg::TIME_W+1)'(1);
		read_ok    = ({1'b0, req.read_bin} < biu_q);
		add_skip   = (req.call_end_ms <= req.call_start_ms) || (biu_q == '0);
		start_past = (div_quo_q[cteh_pkg::TIME_W-1:0]
			>= cteh_pkg::time_t'(biu_q));
		erl_sat    = ({3'b0, rd_data_q[cteh_pkg::TOTAL_W-1:cteh_pkg::LOW_W]} >= step_q);
	end

	// overlap of the call with the current bin, saturating accumulate
	always_comb begin
		start_w   = cteh_pkg::lo_t'(start_q);
		end_w     = cteh_pkg::lo_t'(end_q);
		os_w      = (lo_q > start_w) ? lo_q : start_w;
		oe_w      = (hi_q < end_w) ? hi_q : end_w;
		ovl_w     = oe_w - os_w;
		sum_w     = {1'b0, rd_data_q}
			+ (cteh_pkg::TOTAL_W+1)'(ovl_w[cteh_pkg::TIME_W-1:0]);
		bin_next  = cteh_pkg::biu_t'(bin_q) + cteh_pkg::biu_t'(1);
		walk_done = (hi_q >= end_w) || (bin_next >= biu_q);
	end

	// memory port control
	always_comb begin
		mem_we = (state_q == S_INIT) || (state_q == S_CLR) || (state_q == S_ADD_WR);
		mem_wd = sum_w[cteh_pkg::TOTAL_W] ? cteh_pkg::TOTAL_MAX
			: sum_w[cteh_pkg::TOTAL_W-1:0];
		unique case (state_q)
			S_INIT, S_CLR: begin
				mem_addr = clr_cnt_q;
				mem_wd   = '0;
			end
			S_RD_MEM: mem_addr = rd_bin_q;
			default:  mem_addr = bin_q;
		endcase
	end

	// bin memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_totals_q[mem_addr] <= mem_wd;
		end
		rd_data_q <= bin_totals_q[mem_addr];
	end

	// sequencer and configuration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_cnt_q   <= '0;
			step_q      <= cteh_pkg::STEP_RESET;
			biu_q       <= cteh_pkg::BIU_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			// result register
			if (state_q == S_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT, S_CLR: begin
					clr_cnt_q <= clr_cnt_q + cteh_pkg::bin_t'(1);
					if (sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cfg_acc) begin
						step_q  <= cfg.step_ms;
						state_q <= S_CFG;
					end else if (req_acc) begin
						unique case (req.command)
							cteh_pkg::CMD_ADD: begin
								if (!add_skip) begin
									state_q <= S_DIV;
								end
							end
							cteh_pkg::CMD_READ: begin
								state_q <= read_ok ? S_RD_MEM : S_OUT;
							end
							cteh_pkg::CMD_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= S_CLR;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CFG: begin
					if (step_q == '0) begin
						biu_q   <= '0;
						state_q <= S_IDLE;
					end else if (step_q < cteh_pkg::STEP_FULL) begin
						biu_q   <= cteh_pkg::BIU_FULL;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_last) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					unique case (op_q)
						OP_BIU: begin
							biu_q   <= div_quo_q[cteh_pkg::BIU_W-1:0];
							state_q <= S_IDLE;
						end
						OP_START: state_q <= start_past ? S_IDLE : S_ADD_RD;
						default:  state_q <= S_OUT;
					endcase
				end
				S_ADD_RD: state_q <= S_ADD_WR;
				S_ADD_WR: state_q <= walk_done ? S_IDLE : S_ADD_RD;
				S_RD_MEM: state_q <= S_RD_CHK;
				S_RD_CHK: state_q <= erl_sat ? S_OUT : S_DIV;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: divider, bin walk and staged read result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				start_q  <= req.call_start_ms;
				end_q    <= req.call_end_ms;
				rd_bin_q <= req.read_bin;
				res_erl_q <= '0;
				res_bv_q  <= 1'b0;
				op_q      <= OP_START;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_dvd_q <= {req.call_start_ms, {TPAD_W{1'b0}}};
				div_cnt_q <= cteh_pkg::DIV_CNT_W'(cteh_pkg::TIME_W);
			end
			S_CFG: begin
				op_q      <= OP_BIU;
				div_rem_q <= '0;
				div_quo_q <= '0;
				div_dvd_q <= {day_sum, {DPAD_W{1'b0}}};
				div_cnt_q <= cteh_pkg::DIV_CNT_W'(cteh_pkg::TIME_W + 1);
			end
			S_DIV: begin
				div_rem_q <= div_rem_next;
				div_quo_q <= {div_quo_q[cteh_pkg::DVD_W-2:0], div_ge};
				div_dvd_q <= {div_dvd_q[cteh_pkg::DVD_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q - cteh_pkg::DIV_CNT_W'(1);
			end
			S_POST: begin
				// first bin and its left edge, start minus remainder
				bin_q     <= div_quo_q[cteh_pkg::BIN_W-1:0];
				lo_q      <= cteh_pkg::lo_t'(start_q - div_rem_q);
				res_erl_q <= div_quo_q;
				res_bv_q  <= 1'b1;
			end
			S_ADD_RD: hi_q <= lo_q + cteh_pkg::lo_t'(step_q);
			S_ADD_WR: begin
				bin_q <= bin_next[cteh_pkg::BIN_W-1:0];
				lo_q  <= hi_q;
			end
			S_RD_CHK: begin
				// quotient fits 40 bits once the top part is below step
				op_q      <= OP_ERL;
				res_erl_q <= cteh_pkg::ERL_MAX;
				res_bv_q  <= 1'b1;
				div_rem_q <= cteh_pkg::time_t'(
					rd_data_q[cteh_pkg::TOTAL_W-1:cteh_pkg::LOW_W]);
				div_quo_q <= '0;
				div_dvd_q <= {rd_data_q[cteh_pkg::LOW_W-1:0], {cteh_pkg::FRAC_W{1'b0}}};
				div_cnt_q <= cteh_pkg::DIV_CNT_W'(cteh_pkg::DVD_W);
			end
			default: begin
			end
		endcase
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			rsp_bin_q <= rd_bin_q;
			rsp_erl_q <= res_erl_q;
			rsp_bv_q  <= res_bv_q;
		end
	end

	// checks
	`CTEH_ASSERT_NOW(a_one_port_per_cycle, cfg_acc, !req_acc, "step write and request taken together")
	`CTEH_ASSERT_NOW(a_biu_capped, 1'b1, biu_q <= cteh_pkg::BIU_FULL, "bins in use above capacity")
	`CTEH_ASSERT_NOW(a_div_rem_below_step, state_q == S_DIV, div_rem_q < step_q, "divider remainder not below step")
	`CTEH_ASSERT_NOW(a_invalid_bin_zero, rsp.valid && !rsp.bin_valid, rsp.erlangs_q16 == '0, "invalid bin with nonzero traffic")
	`CTEH_ASSERT_NEXT(a_sweep_blocks_req, state_q == S_CLR && !sweep_last, !req.ready, "request ready during clear sweep")

endmodule

>>> tb/sv/histogram_scoreboard.sv
// ---------------------------------------------------------------------------
// histogram_scoreboard
// Watches the request, step and result channels of the Erlang histogram,
// keeps its own copy of the bin totals and the step, and checks each read
// word against the oldest read still due.
// ---------------------------------------------------------------------------
module histogram_scoreboard
	import cteh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	cteh_req_if  req,
	cteh_rsp_if  rsp,
	cteh_cfg_if  cfg,
	output int   mismatches,
	output int   reads_open
);

	typedef struct packed {
		bin_t bin;
		erl_t erlangs;
		logic in_use;
	} read_word_t;

	total_t     busy_ms [MAX_BINS];
	time_t      step;
	biu_t       bins_used;
	read_word_t reads_due [$];
	read_word_t want;
	int         bad = 0;

	assign mismatches = bad;

	// bins covering the day for a step, capped at the store size
	function automatic biu_t day_bins(time_t s);
		longint unsigned d, n;
		d = s;
		if (d == 0) return '0;
		n = (DAY_MS_I + d - 1) / d;
		return (n > MAX_BINS) ? BIU_FULL : biu_t'(n);
	endfunction

	// add the busy time of one call to every bin it overlaps
	task automatic spread_call(time_t t0, time_t t1);
		longint unsigned s, b, last, lo, hi, from, upto, sum;
		s = step;
		if (t1 <= t0 || s == 0 || bins_used == '0) return;
		last = t1 / s;
		if (last > bins_used - 1) last = bins_used - 1;
		for (b = t0 / s; b <= last; b++) begin
			lo   = b * s;
			hi   = lo + s;
			from = (t0 > lo) ? t0 : lo;
			upto = (t1 < hi) ? t1 : hi;
			if (upto > from) begin
				sum = busy_ms[b] + (upto - from);
				busy_ms[b] = (sum > TOTAL_MAX) ? TOTAL_MAX : total_t'(sum);
			end
		end
	endtask

	// busy ms over the step, Q24.16, truncated, saturating
	function automatic erl_t erlangs_of(total_t tot);
		longint unsigned s, q, r;
		s = step;
		q = tot / s;
		r = tot % s;
		if (q >= (64'd1 << LOW_W)) return ERL_MAX;
		return erl_t'((q << FRAC_W) + ((r << FRAC_W) / s));
	endfunction

	task automatic compare_field(string field, logic [ERL_W-1:0] exp_val,
		logic [ERL_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, got_val);
			bad++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (busy_ms[i]) busy_ms[i] = '0;
			step      = STEP_RESET;
			bins_used = BIU_RESET;
			reads_due.delete();
			reads_open <= 0;
		end else begin
			// result words leave in request order
			if (rsp.valid && rsp.ready) begin
				if (reads_due.size() == 0) begin
					$error("read word with none due: bin_out %0d", rsp.bin_out);
					bad++;
				end else begin
					want = reads_due.pop_front();
					compare_field("bin_out", want.bin, rsp.bin_out);
					compare_field("erlangs_q16", want.erlangs, rsp.erlangs_q16);
					compare_field("bin_valid", want.in_use, rsp.bin_valid);
				end
			end

			// request words update the totals or queue a read
			if (req.valid && req.ready) begin
				case (req.command)
					CMD_ADD: spread_call(req.call_start_ms, req.call_end_ms);
					CMD_READ: begin
						if (req.read_bin < bins_used)
							reads_due.push_back('{req.read_bin,
								erlangs_of(busy_ms[req.read_bin]), 1'b1});
						else
							reads_due.push_back('{req.read_bin, '0, 1'b0});
					end
					CMD_CLEAR: foreach (busy_ms[i]) busy_ms[i] = '0;
					default: ;
				endcase
			end

			// a new step keeps the totals, only the step and the bin count move
			if (cfg.valid && cfg.ready) begin
				step      = cfg.step_ms;
				bins_used = day_bins(cfg.step_ms);
			end

			reads_open <= reads_due.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives the Erlang histogram with directed calls and reads at the reset
// step, then random call, read and clear words under a range of steps, with
// random gaps on both sides. The scoreboard checks every read word.
// ---------------------------------------------------------------------------
module testbench;
	import cteh_pkg::*;

	localparam cmd_t  CMD_UNUSED = 2'd3;
	localparam time_t TIME_ALL   = '1;
	localparam time_t STEP_MIN   = 27'd84375;
	localparam int    WORDS_RUN  = 167;   // counted words per step setting
	localparam int    SETTLE     = 2500;  // full bin walk or clear sweep, with margin
	localparam int    REQ_SIDE   = 0;
	localparam int    RSP_SIDE   = 1;

	logic  clk;
	logic  arst_n;
	int    mismatches;
	int    reads_open;
	int    stretch_left [2];
	bit    stretch_calm [2];
	bin_t  hot_bin;
	time_t step_plan [8];

	cteh_req_if req ();
	cteh_rsp_if rsp ();
	cteh_cfg_if cfg ();

	call_traffic_erlang_histogram dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	histogram_scoreboard score (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.mismatches (mismatches),
		.reads_open (reads_open)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// idle cycles before a word; calm stretches never idle
	function automatic int draw_gap(int side);
		if (stretch_left[side] == 0) begin
			stretch_left[side] = $urandom_range(10, 60);
			stretch_calm[side] = ($urandom_range(0, 3) == 0);
		end
		stretch_left[side]--;
		return stretch_calm[side] ? 0 : $urandom_range(0, 5);
	endfunction

	task automatic send_word(cmd_t c, time_t t0, time_t t1, bin_t b);
		int gap;
		gap = draw_gap(REQ_SIDE);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.command       <= c;
		req.call_start_ms <= t0;
		req.call_end_ms   <= t1;
		req.read_bin      <= b;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic write_step(time_t s);
		cfg.valid   <= 1'b1;
		cfg.step_ms <= s;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// wait for every read, then for any add walk or clear still running
	task automatic settle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (reads_open != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly short calls in the day, some long, misplaced or empty ones
	task automatic send_random_item(time_t s, output bit counted);
		longint unsigned unit, t0, t1;
		int pick;
		unit    = (s == '0) ? 64'd1000 : s;
		counted = 1'b1;
		pick    = $urandom_range(0, 99);
		if (pick < 62) begin
			case ($urandom_range(0, 9))
				0, 1:    t0 = $urandom_range(0, 32'((unit * 8 > TIME_ALL) ? TIME_ALL : unit * 8));
				2:       t0 = DAY_MS_I - $urandom_range(0, 32'((unit > DAY_MS_I) ? DAY_MS_I : unit));
				3:       t0 = $urandom & TIME_ALL;
				default: t0 = $urandom_range(0, DAY_MS_I - 1);
			endcase
			case ($urandom_range(0, 19))
				0:       t1 = $urandom & TIME_ALL;
				1:       t1 = t0 - $urandom_range(0, 32'((t0 < 1000) ? t0 : 1000));
				2:       t1 = t0 + $urandom_range(1, DAY_MS_I);
				3, 4, 5: t1 = t0 + $urandom_range(1, 32'(unit * 4));
				default: t1 = t0 + $urandom_range(1, 32'(unit));
			endcase
			if (t1 > TIME_ALL) t1 = TIME_ALL;
			hot_bin = (s == '0) ? bin_t'($urandom) : bin_t'(t0 / s + $urandom_range(0, 1));
			send_word(CMD_ADD, time_t'(t0), time_t'(t1), bin_t'($urandom));
		end else if (pick < 92) begin
			send_word(CMD_READ, time_t'($urandom), time_t'($urandom),
				$urandom_range(0, 1) ? hot_bin : bin_t'($urandom));
		end else if (pick < 95) begin
			send_word(CMD_CLEAR, time_t'($urandom), time_t'($urandom), bin_t'($urandom));
		end else begin
			send_word(CMD_UNUSED, time_t'($urandom), time_t'($urandom), bin_t'($urandom));
			counted = 1'b0;
		end
	endtask

	// result side: random stall before each word
	initial begin
		int gap;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(RSP_SIDE);
			if (gap != 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin
		bit counted;
		int done;
		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.command       = CMD_ADD;
		req.call_start_ms = '0;
		req.call_end_ms   = '0;
		req.read_bin      = '0;
		cfg.valid         = 1'b0;
		cfg.step_ms       = STEP_RESET;
		hot_bin           = '0;
		// both step extremes, a capped tiny step, zero, the widest value
		step_plan = '{STEP_MIN, DAY_MS, 27'd1, 27'd0,
			time_t'($urandom_range(STEP_MIN, DAY_MS_I)), TIME_ALL,
			time_t'($urandom_range(2, STEP_MIN - 1)), STEP_RESET};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset step, 96 bins
		send_word(CMD_READ, '0, '0, '0);
		send_word(CMD_ADD, 27'd1000, 27'd1000, '0);            // zero length call
		send_word(CMD_ADD, 27'd5000, 27'd1000, '0);            // end before start
		send_word(CMD_ADD, '0, DAY_MS, '0);                    // whole day, all bins full
		send_word(CMD_ADD, 27'd899999, 27'd900001, '0);        // straddles two bins
		send_word(CMD_ADD, 27'd85500000, TIME_ALL, '0);        // runs past the last bin
		send_word(CMD_ADD, TIME_ALL - 27'd1, TIME_ALL, '1);    // starts past the last bin
		send_word(CMD_ADD, 27'd123, 27'd450123, '0);
		send_word(CMD_READ, TIME_ALL, TIME_ALL, '0);
		send_word(CMD_READ, '0, '0, 10'd1);
		send_word(CMD_READ, '0, '0, bin_t'(BIU_RESET - 1));    // last bin in use
		send_word(CMD_READ, '0, '0, bin_t'(BIU_RESET));        // first bin out of use
		send_word(CMD_READ, '0, '0, '1);
		send_word(CMD_UNUSED, TIME_ALL, TIME_ALL, '1);
		send_word(CMD_CLEAR, '0, '0, '0);
		send_word(CMD_READ, '0, '0, '0);
		send_word(CMD_READ, '0, '0, bin_t'(BIU_RESET - 1));
		send_word(CMD_ADD, '0, STEP_RESET, '0);                // exactly one bin
		send_word(CMD_ADD, STEP_RESET, 27'd2700000, '0);
		send_word(CMD_READ, '0, '0, '0);
		send_word(CMD_READ, '0, '0, 10'd1);
		send_word(CMD_READ, '0, '0, 10'd2);
		settle();

		// random words under each step; totals carry across step changes
		foreach (step_plan[p]) begin
			write_step(step_plan[p]);
			send_word(CMD_READ, '0, '0, '0);
			send_word(CMD_READ, '0, '0, '1);
			done = 0;
			while (done < WORDS_RUN) begin
				send_random_item(step_plan[p], counted);
				done += counted;
			end
			// leave a whole-day call behind for the next step to read
			send_word(CMD_ADD, '0, DAY_MS, '0);
			settle();
		end

		if (mismatches == 0)
			$display("** call_traffic_erlang_histogram: PASSED **");
		else
			$display("** call_traffic_erlang_histogram: FAILED **");
		$finish;
	end

	// hang guard
	initial begin
		#150_000_000;
		$display("** call_traffic_erlang_histogram: FAILED **");
		$finish;
	end

endmodule
